>>> sv/bus_poll_scheduler_dead_node_exclusion_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the poll scheduler
// Shared property forms, clocked on aclk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef BUS_POLL_SCHEDULER_DEAD_NODE_EXCLUSION_TOP_MACROS_SVH
`define BUS_POLL_SCHEDULER_DEAD_NODE_EXCLUSION_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BPSDE_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("poll scheduler check failed");

// Consequent must hold in the cycle after the antecedent.
`define BPSDE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("poll scheduler check failed");

`endif

>>> sv/bpsde_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpsde_pkg
// Types, widths and constants shared by the poll scheduler modules.
// ----------------------------------------------------------------------------
package bpsde_pkg;

    localparam int DEF_MAX_CLIENT_ADDRESS = 31;

    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int COUNT_W     = 8;
    localparam int CLIENT_W    = 8;
    localparam int OFFLINE_W   = 9;
    localparam int INTERVAL_W  = 18;
    localparam int DIVIDEND_W  = 18;
    localparam int DIVISOR_W   = 9;
    localparam int ELAPSED_W   = 32;
    localparam int S_DATA_W    = 8;
    localparam int M_DATA_W    = 40;
    localparam int DIV_STEPS   = DIVIDEND_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

    localparam logic [9:0]  MS_PER_SECOND   = 10'd1000;
    localparam logic [7:0]  RST_ROUNDTRIP   = 8'd10;
    localparam logic [15:0] RST_MIN_INTERVAL = 16'd100;
    localparam logic [7:0]  RST_BAD_LIMIT   = 8'd5;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROUNDTRIP    = 2'd0,
        REG_MIN_INTERVAL = 2'd1,
        REG_BAD_LIMIT    = 2'd2
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_ADJUST,
        ST_DIVIDE_GO,
        ST_DIVIDE_WAIT,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [2:0]            pad;
        logic [INTERVAL_W-1:0] poll_interval_ms;
        logic [OFFLINE_W-1:0]  offline_count;
        logic                  all_excluded;
        logic [CLIENT_W-1:0]   poll_client;
        logic                  poll_issue;
    } result_t;

endpackage

>>> sv/bpsde_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpsde_store
// Failure count memory with one write and one registered read port. Entries
// never written since reset read as zero through per-entry valid bits.
// ----------------------------------------------------------------------------
module bpsde_store #(
    parameter int SLOTS = bpsde_pkg::DEF_MAX_CLIENT_ADDRESS + 1,
    parameter int AW    = $clog2(SLOTS)
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         rd_en,
    input  logic [AW-1:0]                rd_addr,
    output logic [bpsde_pkg::COUNT_W-1:0] rd_data,
    input  logic                         wr_en,
    input  logic [AW-1:0]                wr_addr,
    input  logic [bpsde_pkg::COUNT_W-1:0] wr_data
);
    import bpsde_pkg::*;

    logic [COUNT_W-1:0] mem [0:SLOTS-1];
    logic [SLOTS-1:0]   valid_reg;
    logic [COUNT_W-1:0] rd_data_reg;
    logic               rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

>>> sv/bpsde_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpsde_div
// Restoring divider, one quotient bit per cycle, for the poll interval.
// ----------------------------------------------------------------------------
module bpsde_div (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            start,
    input  logic [bpsde_pkg::DIVIDEND_W-1:0] dividend,
    input  logic [bpsde_pkg::DIVISOR_W-1:0]  divisor,
    output logic                            done,
    output logic [bpsde_pkg::DIVIDEND_W-1:0] quotient
);
    import bpsde_pkg::*;

    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVISOR_W-1:0]  dsr_reg, dsr_next;
    logic [DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [DIVISOR_W:0]    trial;

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        cnt_reg <= cnt_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[DIVIDEND_W-1]};
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, dsr_reg}) begin
                rem_next = DIVISOR_W'(trial - {1'b0, dsr_reg});
                quo_next = {quo_reg[DIVIDEND_W-2:0], 1'b1};
            end else begin
                rem_next = trial[DIVISOR_W-1:0];
                quo_next = {quo_reg[DIVIDEND_W-2:0], 1'b0};
            end
            if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

>>> sv/bus_poll_scheduler_dead_node_exclusion_top.sv
`timescale 1ns / 1ps
// A sweep reads every failure count once through the memory's single read
// port, counting excluded clients and finding the next usable one, then a
// restoring divider derives the poll interval. One word is worked on at a
// time; a finished result waits in the output register while the next word
// is accepted.
// ----------------------------------------------------------------------------
// bus_poll_scheduler_dead_node_exclusion_top
// Round-robin poll scheduler for a multidrop bus master with exclusion of
// clients whose failure count has reached the limit.
// ----------------------------------------------------------------------------
`include "bus_poll_scheduler_dead_node_exclusion_top_macros.svh"

module bus_poll_scheduler_dead_node_exclusion_top #(
    parameter int MAX_CLIENT_ADDRESS = bpsde_pkg::DEF_MAX_CLIENT_ADDRESS
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [bpsde_pkg::S_DATA_W-1:0]   s_tdata,  // [0] responded
    input  logic                             s_tuser,  // [0] mode
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [0] poll_issue, [8:1] poll_client, [9] all_excluded,
    // [18:10] offline_count, [36:19] poll_interval_ms
    output logic [bpsde_pkg::M_DATA_W-1:0]   m_tdata,
    input  logic                             cfg_wen,
    input  logic [bpsde_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bpsde_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import bpsde_pkg::*;

    localparam int SLOTS = MAX_CLIENT_ADDRESS + 1;
    localparam int AW    = $clog2(SLOTS);
    localparam logic [AW-1:0]        LAST_ADDR  = AW'(MAX_CLIENT_ADDRESS);
    localparam logic [OFFLINE_W-1:0] SLOTS_CNT  = OFFLINE_W'(SLOTS);
    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

    state_t state_reg, state_next;

    logic [7:0]  roundtrip_reg;
    logic [15:0] min_interval_reg;
    logic [7:0]  limit_reg;

    logic              mode_reg, mode_next;
    logic              resp_reg, resp_next;
    logic [AW-1:0]     rd_addr_reg, rd_addr_next;
    logic              issuing_reg, issuing_next;
    logic              rd_pend_reg, rd_pend_next;
    logic [AW-1:0]     rd_idx_reg, rd_idx_next;
    logic [OFFLINE_W-1:0] off_reg, off_next;
    logic              found_reg, found_next;
    logic [AW-1:0]     found_idx_reg, found_idx_next;
    logic [COUNT_W-1:0] cur_reg, cur_next;
    logic [COUNT_W-1:0] wval_reg, wval_next;
    logic [AW-1:0]     next_client_reg, next_client_next;
    logic [ELAPSED_W-1:0] elapsed_reg, elapsed_next;
    logic              awaiting_reg, awaiting_next;
    result_t           result_reg, result_next;
    logic              m_valid_reg, m_valid_next;

    logic [COUNT_W-1:0]    rd_data;
    logic                  mem_we;
    logic                  div_start;
    logic                  div_done;
    logic [DIVIDEND_W-1:0] div_q;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  alive;
    logic [INTERVAL_W-1:0] interval;
    logic                  rd_ex;
    logic                  upd;
    logic [COUNT_W:0]      inc;
    logic [COUNT_W-1:0]    sat;
    logic                  old_ex;
    logic                  new_ex;
    logic [ELAPSED_W-1:0]  el_inc;
    logic                  load;
    logic                  issue_c;
    logic                  accept;

    bpsde_store #(
        .SLOTS (SLOTS),
        .AW    (AW)
    ) u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (issuing_reg),
        .rd_addr (rd_addr_reg),
        .rd_data (rd_data),
        .wr_en   (mem_we),
        .wr_addr (next_client_reg),
        .wr_data (wval_reg)
    );

    bpsde_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (alive),
        .done     (div_done),
        .quotient (div_q)
    );

    assign dividend = DIVIDEND_W'(roundtrip_reg) * DIVIDEND_W'(MS_PER_SECOND);
    assign alive    = (off_reg == SLOTS_CNT) ? DIVISOR_W'(1) : DIVISOR_W'(SLOTS_CNT - off_reg);
    assign interval = (div_q < DIVIDEND_W'(min_interval_reg)) ?
                      INTERVAL_W'(min_interval_reg) : INTERVAL_W'(div_q);
    assign rd_ex    = rd_data >= limit_reg;
    assign upd      = mode_reg && awaiting_reg && !resp_reg;
    assign inc      = {1'b0, cur_reg} + 1'b1;
    assign sat      = (inc >= {1'b0, limit_reg}) ? limit_reg : inc[COUNT_W-1:0];
    assign old_ex   = cur_reg >= limit_reg;
    assign new_ex   = sat >= limit_reg;
    assign el_inc   = (elapsed_reg == ELAPSED_MAX) ? elapsed_reg : elapsed_reg + 1'b1;
    assign accept   = s_tvalid && s_tready;
    assign load     = (state_reg == ST_FINISH) && (!m_valid_reg || m_tready);
    assign issue_c  = !mode_reg && !awaiting_reg && (el_inc > ELAPSED_W'(interval)) &&
                      found_reg;
    assign mem_we   = load && upd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            roundtrip_reg    <= RST_ROUNDTRIP;
            min_interval_reg <= RST_MIN_INTERVAL;
            limit_reg        <= RST_BAD_LIMIT;
        end else if (cfg_wen) begin
            case (cfg_index)
                REG_ROUNDTRIP:    roundtrip_reg    <= cfg_wdata[7:0];
                REG_MIN_INTERVAL: min_interval_reg <= cfg_wdata;
                REG_BAD_LIMIT:    limit_reg        <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            issuing_reg     <= 1'b0;
            rd_pend_reg     <= 1'b0;
            next_client_reg <= '0;
            elapsed_reg     <= '0;
            awaiting_reg    <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            issuing_reg     <= issuing_next;
            rd_pend_reg     <= rd_pend_next;
            next_client_reg <= next_client_next;
            elapsed_reg     <= elapsed_next;
            awaiting_reg    <= awaiting_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg      <= mode_next;
        resp_reg      <= resp_next;
        rd_addr_reg   <= rd_addr_next;
        rd_idx_reg    <= rd_idx_next;
        off_reg       <= off_next;
        found_reg     <= found_next;
        found_idx_reg <= found_idx_next;
        cur_reg       <= cur_next;
        wval_reg      <= wval_next;
        result_reg    <= result_next;
    end

    always_comb begin
        state_next       = state_reg;
        mode_next        = mode_reg;
        resp_next        = resp_reg;
        rd_addr_next     = rd_addr_reg;
        issuing_next     = issuing_reg;
        rd_pend_next     = 1'b0;
        rd_idx_next      = rd_addr_reg;
        off_next         = off_reg;
        found_next       = found_reg;
        found_idx_next   = found_idx_reg;
        cur_next         = cur_reg;
        wval_next        = wval_reg;
        next_client_next = next_client_reg;
        elapsed_next     = elapsed_reg;
        awaiting_next    = awaiting_reg;
        result_next      = result_reg;
        m_valid_next     = m_valid_reg && !m_tready;
        div_start        = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    mode_next    = s_tuser;
                    resp_next    = s_tdata[0];
                    rd_addr_next = '0;
                    issuing_next = 1'b1;
                    off_next     = '0;
                    found_next   = 1'b0;
                    cur_next     = '0;
                    state_next   = ST_SWEEP;
                end
            end
            ST_SWEEP: begin
                if (issuing_reg) begin
                    rd_pend_next = 1'b1;
                    if (rd_addr_reg == LAST_ADDR) begin
                        issuing_next = 1'b0;
                    end else begin
                        rd_addr_next = rd_addr_reg + 1'b1;
                    end
                end
                if (rd_pend_reg) begin
                    off_next = off_reg + OFFLINE_W'(rd_ex);
                    if (!found_reg && !rd_ex && rd_idx_reg >= next_client_reg) begin
                        found_next     = 1'b1;
                        found_idx_next = rd_idx_reg;
                    end
                    if (rd_idx_reg == next_client_reg) begin
                        cur_next = rd_data;
                    end
                end
                if (!issuing_reg && !rd_pend_reg) begin
                    state_next = ST_ADJUST;
                end
            end
            ST_ADJUST: begin
                wval_next = sat;
                if (upd) begin
                    off_next = off_reg - OFFLINE_W'(old_ex) + OFFLINE_W'(new_ex);
                end
                state_next = ST_DIVIDE_GO;
            end
            ST_DIVIDE_GO: begin
                div_start  = 1'b1;
                state_next = ST_DIVIDE_WAIT;
            end
            ST_DIVIDE_WAIT: begin
                if (div_done) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (load) begin
                    result_next                  = '0;
                    result_next.offline_count    = off_reg;
                    result_next.poll_interval_ms = interval;
                    if (!mode_reg) begin
                        elapsed_next = el_inc;
                        if (!awaiting_reg && el_inc > ELAPSED_W'(interval)) begin
                            if (found_reg) begin
                                next_client_next       = found_idx_reg;
                                awaiting_next          = 1'b1;
                                result_next.poll_issue  = 1'b1;
                                result_next.poll_client = CLIENT_W'(found_idx_reg);
                            end else begin
                                next_client_next         = '0;
                                result_next.all_excluded = 1'b1;
                            end
                        end
                    end else if (awaiting_reg) begin
                        next_client_next = (next_client_reg == LAST_ADDR) ?
                                           '0 : next_client_reg + 1'b1;
                        elapsed_next     = '0;
                        awaiting_next    = 1'b0;
                    end
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = result_reg;

    `BPSDE_ASSERT_NEXT(a_issue_sets_wait, load && issue_c, awaiting_reg)
    `BPSDE_ASSERT_IMP(a_issue_or_none, m_valid_reg, !(result_reg.poll_issue && result_reg.all_excluded))
    `BPSDE_ASSERT_IMP(a_write_at_finish, mem_we, state_reg == ST_FINISH)
    `BPSDE_ASSERT_IMP(a_offline_range, m_valid_reg, result_reg.offline_count <= SLOTS_CNT)
    `BPSDE_ASSERT_IMP(a_ready_quiet, s_tready, !rd_pend_reg && !issuing_reg)

endmodule

>>> tb/sv/bus_poll_scheduler_dead_node_exclusion_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bus_poll_scheduler_dead_node_exclusion_top_tb
// Drives millisecond ticks and poll outcome reports into the poll scheduler
// and checks every result word against a cycle-free model of the scheduler.
// A short directed table covers reset values, the interval floor, exclusion
// of every client and the register extremes. Random phases under several
// register settings follow, with idling on both streams.
// ----------------------------------------------------------------------------
module bus_poll_scheduler_dead_node_exclusion_top_tb;
    import bpsde_pkg::*;

    localparam int SLOTS       = DEF_MAX_CLIENT_ADDRESS + 1;
    localparam int LATENCY     = DEF_MAX_CLIENT_ADDRESS + 25;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int TOTAL_WORDS = 1100;
    localparam int HOLD_AT     = 500;
    localparam int DRAIN_AT    = 800;
    localparam int HOLD_LEN    = 400;
    localparam int N_PHASES    = 6;

    localparam logic MODE_TICK    = 1'b0;
    localparam logic MODE_OUTCOME = 1'b1;

    localparam int PHASE_RT[N_PHASES]    = '{0, 0, 0, 1, 255, 0};
    localparam int PHASE_MIN[N_PHASES]   = '{0, 2, 0, 0, 65535, 1};
    localparam int PHASE_LIM[N_PHASES]   = '{3, 1, 6, 255, 2, 4};
    localparam int PHASE_WORDS[N_PHASES] = '{220, 150, 200, 150, 60, 300};

    typedef enum logic [1:0] {
        ROW_TICK,
        ROW_OUTCOME,
        ROW_SETTINGS
    } row_kind_t;

    typedef struct {
        row_kind_t kind;
        int        resp;
        int        rt;
        int        miniv;
        int        lim;
        bit        typed;
        int        issue;
        int        client;
        int        none;
        int        offl;
        int        iv;
    } plan_row_t;

    localparam int N_ROWS = 23;

    plan_row_t directed_plan [N_ROWS] = '{
        '{ROW_TICK,     0,   0,     0,   0, 1, 0, 0, 0,  0,    312},
        '{ROW_OUTCOME,  1,   0,     0,   0, 1, 0, 0, 0,  0,    312},
        '{ROW_OUTCOME,  0,   0,     0,   0, 1, 0, 0, 0,  0,    312},
        '{ROW_SETTINGS, 0,   0,     0,   3, 0, 0, 0, 0,  0,      0},
        '{ROW_TICK,     1,   0,     0,   0, 1, 1, 0, 0,  0,      0},
        '{ROW_TICK,     0,   0,     0,   0, 0, 0, 0, 0,  0,      0},
        '{ROW_OUTCOME,  0,   0,     0,   0, 0, 0, 0, 0,  0,      0},
        '{ROW_TICK,     0,   0,     0,   0, 0, 0, 0, 0,  0,      0},
        '{ROW_OUTCOME,  1,   0,     0,   0, 0, 0, 0, 0,  0,      0},
        '{ROW_TICK,     1,   0,     0,   0, 0, 0, 0, 0,  0,      0},
        '{ROW_OUTCOME,  0,   0,     0,   0, 0, 0, 0, 0,  0,      0},
        '{ROW_SETTINGS, 0,   0,     0,   1, 0, 0, 0, 0,  0,      0},
        '{ROW_TICK,     0,   0,     0,   0, 0, 0, 0, 0,  0,      0},
        '{ROW_OUTCOME,  0,   0,     0,   0, 0, 0, 0, 0,  0,      0},
        '{ROW_SETTINGS, 0,   0,     0,   0, 0, 0, 0, 0,  0,      0},
        '{ROW_TICK,     0,   0,     0,   0, 1, 0, 0, 1, 32,      0},
        '{ROW_TICK,     1,   0,     0,   0, 0, 0, 0, 0,  0,      0},
        '{ROW_SETTINGS, 0, 255,     0,   0, 0, 0, 0, 0,  0,      0},
        '{ROW_TICK,     0,   0,     0,   0, 1, 0, 0, 0, 32, 255000},
        '{ROW_SETTINGS, 0, 255, 65535, 255, 0, 0, 0, 0,  0,      0},
        '{ROW_TICK,     1,   0,     0,   0, 1, 0, 0, 0,  0,  65535},
        '{ROW_SETTINGS, 0,   1,     0, 255, 0, 0, 0, 0,  0,      0},
        '{ROW_OUTCOME,  0,   0,     0,   0, 0, 0, 0, 0,  0,      0}
    };

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  cfg_wen;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    // Scheduler model state.
    int unsigned roundtrip_s;
    int unsigned min_gap_ms;
    int unsigned fail_limit;
    logic [7:0]  fail_cnt [SLOTS];
    int unsigned poll_cursor;
    logic [31:0] ms_since_poll;
    bit          poll_pending;

    result_t     awaited_results [$];
    int          failures;
    int          words_sent;
    int          cycle_count;
    int          send_idle_pct;
    int          recv_idle_pct;
    bit          hold_req;
    int          hold_cycles;

    bus_poll_scheduler_dead_node_exclusion_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic bit client_barred(int unsigned addr);
        return fail_cnt[addr] >= fail_limit;
    endfunction

    function automatic int unsigned offline_clients();
        int unsigned n;
        n = 0;
        for (int i = 0; i < SLOTS; i++) begin
            if (client_barred(i)) n++;
        end
        return n;
    endfunction

    function automatic int unsigned interval_for(int unsigned offline);
        int unsigned alive;
        int unsigned iv;
        alive = SLOTS - offline;
        if (alive == 0) alive = 1;
        iv = (roundtrip_s * 1000) / alive;
        if (iv < min_gap_ms) iv = min_gap_ms;
        return iv;
    endfunction

    // Advances the scheduler model by one accepted word and returns its result.
    function automatic result_t schedule_step(logic mode_bit, logic resp);
        result_t     res;
        int unsigned iv;
        int unsigned c;
        int unsigned v;
        int unsigned offl;
        res = '0;
        if (poll_cursor >= SLOTS) poll_cursor = 0;
        if (mode_bit == MODE_TICK) begin
            iv = interval_for(offline_clients());
            if (ms_since_poll != 32'hFFFF_FFFF) ms_since_poll++;
            if (!poll_pending && ms_since_poll > iv) begin
                c = poll_cursor;
                while (c < SLOTS && client_barred(c)) c++;
                if (c >= SLOTS) begin
                    poll_cursor = 0;
                    res.all_excluded = 1'b1;
                end else begin
                    poll_cursor = c;
                    res.poll_issue = 1'b1;
                    res.poll_client = c[CLIENT_W-1:0];
                    poll_pending = 1'b1;
                end
            end
        end else if (poll_pending) begin
            if (!resp) begin
                v = fail_cnt[poll_cursor] + 1;
                if (v >= fail_limit) v = fail_limit;
                fail_cnt[poll_cursor] = v[7:0];
            end
            poll_cursor = (poll_cursor == SLOTS - 1) ? 0 : poll_cursor + 1;
            ms_since_poll = '0;
            poll_pending = 1'b0;
        end
        offl = offline_clients();
        res.offline_count = offl[OFFLINE_W-1:0];
        res.poll_interval_ms = INTERVAL_W'(interval_for(offl));
        return res;
    endfunction

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge aclk);
    endtask

    // Writes all three registers on consecutive edges while the block is idle.
    task automatic load_settings(int rt, int miniv, int lim);
        wait_drained();
        cfg_wen   <= 1'b1;
        cfg_index <= REG_ROUNDTRIP;
        cfg_wdata <= CFG_DATA_W'(rt);
        @(posedge aclk);
        roundtrip_s = rt;
        cfg_index <= REG_MIN_INTERVAL;
        cfg_wdata <= CFG_DATA_W'(miniv);
        @(posedge aclk);
        min_gap_ms = miniv;
        cfg_index <= REG_BAD_LIMIT;
        cfg_wdata <= CFG_DATA_W'(lim);
        @(posedge aclk);
        fail_limit = lim;
        cfg_wen <= 1'b0;
    endtask

    task automatic send_word(logic mode_bit, logic resp, bit use_typed, result_t typed_res);
        result_t predicted;
        case (words_sent * 3 / TOTAL_WORDS)
            0: begin
                send_idle_pct = 27;
                recv_idle_pct = 84;
            end
            1: begin
                send_idle_pct = 84;
                recv_idle_pct = 27;
            end
            default: begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
        endcase
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode_bit;
        s_tdata  <= {{(S_DATA_W-1){1'b0}}, resp};
        do @(posedge aclk); while (!s_tready);
        predicted = schedule_step(mode_bit, resp);
        awaited_results.insert(awaited_results.size(), use_typed ? typed_res : predicted);
        words_sent++;
    endtask

    initial begin
        result_t   typed_res;
        logic      mode_bit;
        plan_row_t row;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        cfg_wen   = 1'b0;
        cfg_index = REG_ROUNDTRIP;
        cfg_wdata = '0;
        failures  = 0;
        words_sent = 0;
        hold_req  = 1'b0;
        send_idle_pct = 27;
        recv_idle_pct = 84;
        roundtrip_s = RST_ROUNDTRIP;
        min_gap_ms  = RST_MIN_INTERVAL;
        fail_limit  = RST_BAD_LIMIT;
        foreach (fail_cnt[i]) fail_cnt[i] = '0;
        poll_cursor   = 0;
        ms_since_poll = '0;
        poll_pending  = 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        for (int r = 0; r < N_ROWS; r++) begin
            row = directed_plan[r];
            if (row.kind == ROW_SETTINGS) begin
                load_settings(row.rt, row.miniv, row.lim);
            end else begin
                typed_res = '0;
                typed_res.poll_issue       = row.issue[0];
                typed_res.poll_client      = row.client[CLIENT_W-1:0];
                typed_res.all_excluded     = row.none[0];
                typed_res.offline_count    = row.offl[OFFLINE_W-1:0];
                typed_res.poll_interval_ms = row.iv[INTERVAL_W-1:0];
                mode_bit = (row.kind == ROW_OUTCOME) ? MODE_OUTCOME : MODE_TICK;
                send_word(mode_bit, row.resp[0], row.typed, typed_res);
            end
        end

        // Mostly well-formed poll and outcome pairs, with stray outcomes as noise.
        for (int p = 0; p < N_PHASES; p++) begin
            load_settings(PHASE_RT[p], PHASE_MIN[p], PHASE_LIM[p]);
            for (int i = 0; i < PHASE_WORDS[p]; i++) begin
                if (poll_pending)
                    mode_bit = ($urandom_range(99) < 85) ? MODE_OUTCOME : MODE_TICK;
                else
                    mode_bit = ($urandom_range(99) < 8) ? MODE_OUTCOME : MODE_TICK;
                send_word(mode_bit, 1'($urandom_range(1)), 1'b0, '0);
                if (words_sent == HOLD_AT) hold_req = 1'b1;
                if (words_sent == DRAIN_AT) wait_drained();
            end
        end

        wait_drained();
        repeat (2 * LATENCY) @(posedge aclk);
        if (failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        m_tready = 1'b0;
        hold_cycles = 0;
        forever begin
            @(posedge aclk);
            if (hold_cycles != 0) begin
                m_tready <= 1'b0;
                hold_cycles--;
            end else if (hold_req) begin
                hold_req = 1'b0;
                hold_cycles = HOLD_LEN;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic check_field(string name, longint want, longint seen);
        if (want != seen) begin
            $error("%s: expected %0d, got %0d", name, want, seen);
            failures++;
        end
    endtask

    always @(posedge aclk) begin
        result_t want;
        result_t seen;
        if (aresetn && m_tvalid && m_tready) begin
            seen = result_t'(m_tdata);
            if (awaited_results.size() == 0) begin
                $error("result word arrived with no expectation waiting");
                failures++;
            end else begin
                want = awaited_results.pop_front();
                check_field("poll_issue", want.poll_issue, seen.poll_issue);
                check_field("poll_client", want.poll_client, seen.poll_client);
                check_field("all_excluded", want.all_excluded, seen.all_excluded);
                check_field("offline_count", want.offline_count, seen.offline_count);
                check_field("poll_interval_ms", want.poll_interval_ms,
                            seen.poll_interval_ms);
            end
        end
    end

    initial cycle_count = 0;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

endmodule
